### rtl/smas_pkg.sv
// Shared types, constants and lookup functions for the sprite motion/alarm unit.
// No dependencies; used by every other file of the block.
package smas_pkg;

  localparam int NUM_ALARMS_DEF = 12;
  localparam int ALARM_W = 21;
  localparam int FIX_W   = 32;
  localparam int ANGLE_W = 17;
  localparam int FRIC_W  = 31;
  localparam int CORDIC_STEPS = 16;

  localparam logic [ANGLE_W-1:0] FULL_TURN    = 17'd92160;
  localparam logic [ANGLE_W-1:0] QUARTER_TURN = 17'd23040;
  localparam logic [ANGLE_W-1:0] ANGLE_RESET  = 17'd69120;
  localparam logic signed [33:0] CORDIC_START = 34'sd652032874;

  // register map, index = paddr[3:2]
  localparam logic [1:0] REG_GRAV_STRENGTH = 2'd0;
  localparam logic [1:0] REG_GRAV_ANGLE    = 2'd1;
  localparam logic [1:0] REG_FRICTION      = 2'd2;

  localparam logic EV_ALARM = 1'b0;
  localparam logic EV_STEP  = 1'b1;

  typedef enum logic [1:0] {
    OP_TICK        = 2'd0,
    OP_LOAD_ALARM  = 2'd1,
    OP_LOAD_MOTION = 2'd2,
    OP_NONE        = 2'd3
  } op_e;

  typedef struct packed {
    op_e                      op;
    logic [1:0]               step_kind;
    logic [3:0]               alarm_slot;
    logic signed [ALARM_W-1:0] alarm_load;
    logic signed [FIX_W-1:0]  load_x;
    logic signed [FIX_W-1:0]  load_y;
    logic signed [FIX_W-1:0]  load_hspeed;
    logic signed [FIX_W-1:0]  load_vspeed;
  } item_t;

  typedef struct packed {
    logic signed [FIX_W-1:0] strength;
    logic [ANGLE_W-1:0]      angle;
    logic [FRIC_W-1:0]       friction;
  } cfg_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_ALARM, ST_MOVE, ST_TRIG_PREP, ST_CORDIC, ST_GMUL, ST_GADD,
    ST_SQ_H, ST_SQ_V, ST_SQ_SUM, ST_SQRT, ST_MAGCHK, ST_DMUL, ST_DINIT,
    ST_DIV, ST_DAPPLY, ST_STEP
  } state_t;

  // atan(2^-i) in 1/65536 degree
  function automatic logic signed [24:0] atan_lut(input logic [3:0] i);
    logic signed [24:0] r;
    unique case (i)
      4'd0:  r = 25'sd2949120;
      4'd1:  r = 25'sd1740967;
      4'd2:  r = 25'sd919879;
      4'd3:  r = 25'sd466945;
      4'd4:  r = 25'sd234379;
      4'd5:  r = 25'sd117304;
      4'd6:  r = 25'sd58666;
      4'd7:  r = 25'sd29335;
      4'd8:  r = 25'sd14668;
      4'd9:  r = 25'sd7334;
      4'd10: r = 25'sd3667;
      4'd11: r = 25'sd1833;
      4'd12: r = 25'sd917;
      4'd13: r = 25'sd458;
      4'd14: r = 25'sd229;
      4'd15: r = 25'sd115;
      default: r = 25'sd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [FIX_W-1:0] sat_fix(input logic signed [35:0] v);
    logic signed [FIX_W-1:0] r;
    if (v > 36'sh0_7FFF_FFFF)       r = 32'sh7FFF_FFFF;
    else if (v < -36'sh0_8000_0000) r = 32'sh8000_0000;
    else                            r = v[FIX_W-1:0];
    return r;
  endfunction

endpackage

### rtl/smas_if.sv
// Valid/ready channel interfaces for input items and result items.
// Depends on smas_pkg for field widths.
interface smas_in_if;
  logic valid;
  logic ready;
  logic [1:0] mode;
  logic [1:0] step_kind;
  logic [3:0] alarm_slot;
  logic signed [smas_pkg::ALARM_W-1:0] alarm_load;
  logic signed [smas_pkg::FIX_W-1:0] load_x;
  logic signed [smas_pkg::FIX_W-1:0] load_y;
  logic signed [smas_pkg::FIX_W-1:0] load_hspeed;
  logic signed [smas_pkg::FIX_W-1:0] load_vspeed;
  modport source(output valid, mode, step_kind, alarm_slot, alarm_load, load_x, load_y,
                 load_hspeed, load_vspeed, input ready);
  modport sink(input valid, mode, step_kind, alarm_slot, alarm_load, load_x, load_y,
               load_hspeed, load_vspeed, output ready);
endinterface

interface smas_out_if;
  logic valid;
  logic ready;
  logic event_kind;
  logic [3:0] event_code;
  logic signed [smas_pkg::FIX_W-1:0] pos_x;
  logic signed [smas_pkg::FIX_W-1:0] pos_y;
  logic signed [smas_pkg::FIX_W-1:0] speed_h;
  logic signed [smas_pkg::FIX_W-1:0] speed_v;
  logic last;
  modport source(output valid, event_kind, event_code, pos_x, pos_y, speed_h, speed_v, last,
                 input ready);
  modport sink(input valid, event_kind, event_code, pos_x, pos_y, speed_h, speed_v, last,
               output ready);
endinterface

### rtl/smas_front.sv
// Front end: accepts input beats, classifies them and queues them (2 entries).
// Depends on smas_pkg and smas_if.
module smas_front #(
  parameter int NUM_ALARMS = smas_pkg::NUM_ALARMS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  smas_in_if.sink           req,
  output smas_pkg::item_t   head,
  output logic              head_valid,
  input  logic              pop
);

  smas_pkg::item_t q_mem [2];
  logic       wp, rp;
  logic [1:0] cnt;
  smas_pkg::item_t it;
  logic keep, push;

  always_comb begin
    it.op          = smas_pkg::op_e'(req.mode);
    it.step_kind   = req.step_kind;
    it.alarm_slot  = req.alarm_slot;
    it.alarm_load  = req.alarm_load;
    it.load_x      = req.load_x;
    it.load_y      = req.load_y;
    it.load_hspeed = req.load_hspeed;
    it.load_vspeed = req.load_vspeed;
    // unused mode and out-of-range slots have no effect: drop them here
    keep = (it.op != smas_pkg::OP_NONE) &&
           !(it.op == smas_pkg::OP_LOAD_ALARM && 6'(req.alarm_slot) >= 6'(NUM_ALARMS));
  end

  assign req.ready  = (cnt != 2'd2);
  assign push       = req.valid && req.ready && keep;
  assign head       = q_mem[rp];
  assign head_valid = (cnt != 2'd0);

  always_ff @(posedge clk) begin
    if (push) q_mem[wp] <= it;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop)  rp <= ~rp;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

### rtl/smas_back.sv
// Back end: alarm scan, motion update, CORDIC gravity, sqrt/divide friction.
// Depends on smas_pkg and smas_if; owns the result output register.
module smas_back #(
  parameter int NUM_ALARMS = smas_pkg::NUM_ALARMS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  smas_pkg::cfg_t  cfg,
  input  smas_pkg::item_t head,
  input  logic            head_valid,
  output logic            pop,
  smas_out_if.source      rsp
);

  localparam int IW = (NUM_ALARMS > 1) ? $clog2(NUM_ALARMS) : 1;

  smas_pkg::state_t st, st_next;
  logic [IW-1:0] idx, idx_next;
  logic signed [20:0] alarm [NUM_ALARMS];
  logic signed [20:0] alarm_next [NUM_ALARMS];
  logic signed [31:0] px, py, vh, vv, px_next, py_next, vh_next, vv_next;
  logic signed [33:0] cx, cy, cx_next, cy_next;
  logic signed [24:0] cz, cz_next;
  logic [1:0]  quad, quad_next;
  logic [4:0]  cnt, cnt_next;
  logic        sel, sel_next;
  logic signed [67:0] prod, prod_next;
  logic [63:0] sq_n, sq_n_next, root, root_next, sbit, sbit_next, dv, dv_next;
  logic [31:0] mag, mag_next;

  logic ov, ov_next, emit_ok;
  logic o_kind, o_kind_next, o_last, o_last_next;
  logic [3:0] o_code, o_code_next;
  logic signed [31:0] o_px, o_py, o_sh, o_sv, o_px_next, o_py_next, o_sh_next, o_sv_next;

  // scratch
  logic signed [33:0] mul_a, mul_b, dx, dy, tc, ts;
  logic signed [20:0] cur;
  logic [4:0]  idx5, slot5;
  logic [16:0] ang, resid;
  logic [1:0]  qd;
  logic signed [67:0] rnd;
  logic [63:0] trial;
  logic [32:0] r2;
  logic [31:0] absc;
  logic signed [31:0] comp;

  assign emit_ok = !ov || rsp.ready;

  always_comb begin
    st_next = st; idx_next = idx;
    for (int k = 0; k < NUM_ALARMS; k++) alarm_next[k] = alarm[k];
    px_next = px; py_next = py; vh_next = vh; vv_next = vv;
    cx_next = cx; cy_next = cy; cz_next = cz; quad_next = quad;
    cnt_next = cnt; sel_next = sel; prod_next = prod;
    sq_n_next = sq_n; root_next = root; sbit_next = sbit; dv_next = dv; mag_next = mag;
    ov_next = rsp.ready ? 1'b0 : ov;
    o_kind_next = o_kind; o_code_next = o_code; o_last_next = o_last;
    o_px_next = o_px; o_py_next = o_py; o_sh_next = o_sh; o_sv_next = o_sv;
    pop = 1'b0;
    mul_a = '0; mul_b = '0;
    cur = alarm[idx];
    idx5 = 5'(idx);
    slot5 = 5'(head.alarm_slot);
    dx = cy >>> cnt[3:0];
    dy = cx >>> cnt[3:0];
    ang = (cfg.angle >= smas_pkg::FULL_TURN) ? cfg.angle - smas_pkg::FULL_TURN : cfg.angle;
    if (ang >= 17'(3 * smas_pkg::QUARTER_TURN))      qd = 2'd3;
    else if (ang >= 17'(2 * smas_pkg::QUARTER_TURN)) qd = 2'd2;
    else if (ang >= smas_pkg::QUARTER_TURN)          qd = 2'd1;
    else                                             qd = 2'd0;
    resid = ang - 17'(qd * smas_pkg::QUARTER_TURN);
    unique case (quad)
      2'd0: begin tc = cx;  ts = cy;  end
      2'd1: begin tc = -cy; ts = cx;  end
      2'd2: begin tc = -cx; ts = -cy; end
      default: begin tc = cy; ts = -cx; end
    endcase
    rnd = (prod + 68'sd536870912) >>> 30;
    trial = root + sbit;
    r2 = {dv[63:32], dv[31]};
    comp = sel ? vv : vh;
    absc = comp[31] ? 32'(-comp) : comp;

    unique case (st)
      smas_pkg::ST_IDLE: begin
        if (head_valid) begin
          unique case (head.op)
            smas_pkg::OP_LOAD_ALARM: begin
              alarm_next[slot5[IW-1:0]] = head.alarm_load;
              pop = 1'b1;
            end
            smas_pkg::OP_LOAD_MOTION: begin
              px_next = head.load_x; py_next = head.load_y;
              vh_next = head.load_hspeed; vv_next = head.load_vspeed;
              pop = 1'b1;
            end
            smas_pkg::OP_TICK: begin
              idx_next = '0;
              st_next = smas_pkg::ST_ALARM;
            end
            default: pop = 1'b1;
          endcase
        end
      end
      smas_pkg::ST_ALARM: begin
        if (!(cur == 21'sd0 && !emit_ok)) begin
          if (cur >= 21'sd0) alarm_next[idx] = cur - 21'sd1;
          if (cur == 21'sd0) begin
            ov_next = 1'b1;
            o_kind_next = smas_pkg::EV_ALARM; o_code_next = idx5[3:0]; o_last_next = 1'b0;
            o_px_next = '0; o_py_next = '0; o_sh_next = '0; o_sv_next = '0;
          end
          if (idx == IW'(NUM_ALARMS - 1)) st_next = smas_pkg::ST_MOVE;
          else idx_next = IW'(idx + 1'b1);
        end
      end
      smas_pkg::ST_MOVE: begin
        px_next = smas_pkg::sat_fix(36'(px) + 36'(vh));
        py_next = smas_pkg::sat_fix(36'(py) + 36'(vv));
        if (cfg.strength != '0) st_next = smas_pkg::ST_TRIG_PREP;
        else if (cfg.friction != '0) st_next = smas_pkg::ST_SQ_H;
        else st_next = smas_pkg::ST_STEP;
      end
      smas_pkg::ST_TRIG_PREP: begin
        cx_next = smas_pkg::CORDIC_START;
        cy_next = '0;
        cz_next = 25'({resid, 8'd0});
        quad_next = qd;
        cnt_next = '0;
        st_next = smas_pkg::ST_CORDIC;
      end
      smas_pkg::ST_CORDIC: begin
        if (!cz[24]) begin
          cx_next = cx - dx; cy_next = cy + dy; cz_next = cz - smas_pkg::atan_lut(cnt[3:0]);
        end else begin
          cx_next = cx + dx; cy_next = cy - dy; cz_next = cz + smas_pkg::atan_lut(cnt[3:0]);
        end
        cnt_next = cnt + 5'd1;
        if (cnt == 5'(smas_pkg::CORDIC_STEPS - 1)) begin
          sel_next = 1'b0;
          st_next = smas_pkg::ST_GMUL;
        end
      end
      smas_pkg::ST_GMUL: begin
        mul_a = 34'(cfg.strength);
        mul_b = sel ? tc : ts;
        prod_next = mul_a * mul_b;
        st_next = smas_pkg::ST_GADD;
      end
      smas_pkg::ST_GADD: begin
        if (!sel) begin
          vv_next = smas_pkg::sat_fix(36'(vv) + rnd[35:0]);
          sel_next = 1'b1;
          st_next = smas_pkg::ST_GMUL;
        end else begin
          vh_next = smas_pkg::sat_fix(36'(vh) + rnd[35:0]);
          st_next = (cfg.friction != '0) ? smas_pkg::ST_SQ_H : smas_pkg::ST_STEP;
        end
      end
      smas_pkg::ST_SQ_H: begin
        mul_a = 34'(vh); mul_b = 34'(vh);
        prod_next = mul_a * mul_b;
        st_next = smas_pkg::ST_SQ_V;
      end
      smas_pkg::ST_SQ_V: begin
        sq_n_next = prod[63:0];
        mul_a = 34'(vv); mul_b = 34'(vv);
        prod_next = mul_a * mul_b;
        st_next = smas_pkg::ST_SQ_SUM;
      end
      smas_pkg::ST_SQ_SUM: begin
        sq_n_next = sq_n + prod[63:0];
        root_next = '0;
        sbit_next = 64'h4000_0000_0000_0000;
        cnt_next = '0;
        st_next = smas_pkg::ST_SQRT;
      end
      smas_pkg::ST_SQRT: begin
        if (sq_n >= trial) begin
          sq_n_next = sq_n - trial;
          root_next = (root >> 1) + sbit;
        end else begin
          root_next = root >> 1;
        end
        sbit_next = sbit >> 2;
        cnt_next = cnt + 5'd1;
        if (cnt == 5'd31) st_next = smas_pkg::ST_MAGCHK;
      end
      smas_pkg::ST_MAGCHK: begin
        mag_next = root[31:0];
        if (root[31:0] > {1'b0, cfg.friction}) begin
          sel_next = 1'b0;
          st_next = smas_pkg::ST_DMUL;
        end else begin
          vh_next = '0; vv_next = '0;
          st_next = smas_pkg::ST_STEP;
        end
      end
      smas_pkg::ST_DMUL: begin
        mul_a = {2'b00, absc};
        mul_b = {3'b000, cfg.friction};
        prod_next = mul_a * mul_b;
        st_next = smas_pkg::ST_DINIT;
      end
      smas_pkg::ST_DINIT: begin
        dv_next = prod[63:0];
        cnt_next = '0;
        st_next = smas_pkg::ST_DIV;
      end
      smas_pkg::ST_DIV: begin
        if (r2 >= {1'b0, mag}) dv_next = {32'(r2 - {1'b0, mag}), dv[30:0], 1'b1};
        else                   dv_next = {r2[31:0], dv[30:0], 1'b0};
        cnt_next = cnt + 5'd1;
        if (cnt == 5'd31) st_next = smas_pkg::ST_DAPPLY;
      end
      smas_pkg::ST_DAPPLY: begin
        if (!sel) begin
          vh_next = comp[31] ? comp + $signed(dv[31:0]) : comp - $signed(dv[31:0]);
          sel_next = 1'b1;
          st_next = smas_pkg::ST_DMUL;
        end else begin
          vv_next = comp[31] ? comp + $signed(dv[31:0]) : comp - $signed(dv[31:0]);
          st_next = smas_pkg::ST_STEP;
        end
      end
      smas_pkg::ST_STEP: begin
        if (emit_ok) begin
          ov_next = 1'b1;
          o_kind_next = smas_pkg::EV_STEP; o_code_next = {2'b00, head.step_kind};
          o_last_next = 1'b1;
          o_px_next = px; o_py_next = py; o_sh_next = vh; o_sv_next = vv;
          pop = 1'b1;
          st_next = smas_pkg::ST_IDLE;
        end
      end
      default: st_next = smas_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= smas_pkg::ST_IDLE;
      ov <= 1'b0;
      px <= '0; py <= '0; vh <= '0; vv <= '0;
      for (int k = 0; k < NUM_ALARMS; k++) alarm[k] <= -21'sd1;
    end else begin
      st <= st_next;
      ov <= ov_next;
      px <= px_next; py <= py_next; vh <= vh_next; vv <= vv_next;
      for (int k = 0; k < NUM_ALARMS; k++) alarm[k] <= alarm_next[k];
    end
  end

  always_ff @(posedge clk) begin
    idx <= idx_next; cx <= cx_next; cy <= cy_next; cz <= cz_next; quad <= quad_next;
    cnt <= cnt_next; sel <= sel_next; prod <= prod_next;
    sq_n <= sq_n_next; root <= root_next; sbit <= sbit_next; dv <= dv_next; mag <= mag_next;
    o_kind <= o_kind_next; o_code <= o_code_next; o_last <= o_last_next;
    o_px <= o_px_next; o_py <= o_py_next; o_sh <= o_sh_next; o_sv <= o_sv_next;
  end

  assign rsp.valid      = ov;
  assign rsp.event_kind = o_kind;
  assign rsp.event_code = o_code;
  assign rsp.pos_x      = o_px;
  assign rsp.pos_y      = o_py;
  assign rsp.speed_h    = o_sh;
  assign rsp.speed_v    = o_sv;
  assign rsp.last       = o_last;

  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    st == smas_pkg::ST_ALARM |-> 6'(idx) < 6'(NUM_ALARMS))
    else $error("alarm scan index past last alarm");

  a_step_pops: assert property (@(posedge clk) disable iff (rst)
    (st == smas_pkg::ST_STEP && emit_ok) |-> pop)
    else $error("step result sent without retiring the tick");

  a_fric_stop: assert property (@(posedge clk) disable iff (rst)
    (st == smas_pkg::ST_MAGCHK && root[31:0] <= {1'b0, cfg.friction}) |=>
      (vh == '0 && vv == '0))
    else $error("friction did not stop slow object");

endmodule

### rtl/sprite_motion_alarm_step.sv
// Top level of the sprite motion/alarm unit: APB config registers, front and back.
// Depends on smas_pkg, smas_if, smas_front and smas_back.
//
// One object's motion and alarms in Q16.16. Items come in on req; a tick returns one
// beat per alarm that expires (ascending alarm number, last=0) followed by a step beat
// (last=1) carrying the new position and speed. Alarm and motion loads return nothing.
// Items are taken one at a time by a sequencer. A load is retired in the dispatch state.
// A tick runs dispatch, the serial alarm scan (one counter per cycle while no alarm beat
// is held up by rsp), the position add, with gravity on the quadrant fold, a 16-step
// CORDIC and one shared multiplier used twice, and with friction on the squared magnitude
// and 32-step square root plus two 32-step restoring divides (product, load, 32 steps,
// apply), then the step beat. Stalls on rsp can hold the alarm scan and the step beat.
// A 2-entry queue in front lets new items land while a tick is running, and the output
// register lets the back end continue while a result waits.
// Registers (byte address): 0 gravity_strength, 4 gravity_angle, 8 friction_amount.
module sprite_motion_alarm_step #(
  parameter int NUM_ALARMS = smas_pkg::NUM_ALARMS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  smas_in_if.sink     req,
  smas_out_if.source  rsp
);

  smas_pkg::cfg_t  cfg;
  smas_pkg::item_t head;
  logic head_valid, pop;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // config registers; write them only while the block is idle (the block does not enforce it)
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.strength <= '0;
      cfg.angle    <= smas_pkg::ANGLE_RESET;
      cfg.friction <= '0;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        smas_pkg::REG_GRAV_STRENGTH: cfg.strength <= pwdata;
        smas_pkg::REG_GRAV_ANGLE:    cfg.angle    <= pwdata[16:0];
        smas_pkg::REG_FRICTION:      cfg.friction <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      smas_pkg::REG_GRAV_STRENGTH: prdata = cfg.strength;
      smas_pkg::REG_GRAV_ANGLE:    prdata = {15'd0, cfg.angle};
      smas_pkg::REG_FRICTION:      prdata = {1'b0, cfg.friction};
      default:                     prdata = '0;
    endcase
  end

  smas_front #(.NUM_ALARMS(NUM_ALARMS)) u_front (
    .clk(clk), .rst(rst), .req(req), .head(head), .head_valid(head_valid), .pop(pop)
  );

  smas_back #(.NUM_ALARMS(NUM_ALARMS)) u_back (
    .clk(clk), .rst(rst), .cfg(cfg), .head(head), .head_valid(head_valid), .pop(pop),
    .rsp(rsp)
  );

endmodule

### test/smas_motion_checker.sv
// Scoreboard for the sprite motion/alarm unit: follows APB writes and the req channel,
// predicts the rsp beats and compares them field by field.
// Depends on smas_pkg and the smas_in_if / smas_out_if interfaces.
module smas_motion_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  smas_in_if          req,
  smas_out_if         rsp,
  output int          misses,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic       kind;
    logic [3:0] code;
    int         px;
    int         py;
    int         sh;
    int         sv;
    logic       last;
  } beat_t;

  localparam longint ATAN_DEG16 [16] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115
  };

  beat_t                         expected_beats[$];
  int                            obj_x, obj_y, vel_h, vel_v;
  int                            alarm_cnt[smas_pkg::NUM_ALARMS_DEF];
  int                            grav;
  logic [smas_pkg::ANGLE_W-1:0]  grav_dir;
  logic [smas_pkg::FRIC_W-1:0]   drag;

  function automatic int clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return int'(v);
  endfunction

  // CORDIC sin/cos in Q2.30, quadrant folded after the rotation
  function automatic void rotate(input logic [smas_pkg::ANGLE_W-1:0] ang, output longint c,
                                 output longint s);
    int     a, q;
    longint x, y, z, dx, dy;
    a = int'(ang) % int'(smas_pkg::FULL_TURN);
    q = a / int'(smas_pkg::QUARTER_TURN);
    z = longint'(a - q * int'(smas_pkg::QUARTER_TURN)) * 256;
    x = 652032874;
    y = 0;
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - ATAN_DEG16[i];
      end else begin
        x = x + dx; y = y - dy; z = z + ATAN_DEG16[i];
      end
    end
    case (q)
      0: begin c = x;  s = y;  end
      1: begin c = -y; s = x;  end
      2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endfunction

  function automatic longint unsigned root64(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic int drag_comp(int comp, longint unsigned f, longint unsigned mag);
    longint          c;
    longint unsigned a, cut;
    c = comp;
    a = (c < 0) ? -c : c;
    cut = (a * f) / mag;
    return (c < 0) ? int'(c + longint'(cut)) : int'(c - longint'(cut));
  endfunction

  function automatic void check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      misses++;
    end
  endfunction

  // one accepted req beat -> state update and expected rsp beats
  task automatic advance_object();
    beat_t           b;
    longint          c, s, h, v;
    longint unsigned mag;
    case (smas_pkg::op_e'(req.mode))
      smas_pkg::OP_LOAD_ALARM: begin
        if (req.alarm_slot < smas_pkg::NUM_ALARMS_DEF)
          alarm_cnt[req.alarm_slot] = int'(req.alarm_load);
      end
      smas_pkg::OP_LOAD_MOTION: begin
        obj_x = req.load_x;
        obj_y = req.load_y;
        vel_h = req.load_hspeed;
        vel_v = req.load_vspeed;
      end
      smas_pkg::OP_TICK: begin
        for (int i = 0; i < smas_pkg::NUM_ALARMS_DEF; i++) begin
          if (alarm_cnt[i] >= 0) begin
            alarm_cnt[i]--;
            if (alarm_cnt[i] == -1) begin
              b = '{smas_pkg::EV_ALARM, 4'(i), 0, 0, 0, 0, 1'b0};
              expected_beats.push_back(b);
            end
          end
        end
        obj_x = clamp32(longint'(obj_x) + longint'(vel_h));
        obj_y = clamp32(longint'(obj_y) + longint'(vel_v));
        if (grav != 0) begin
          rotate(grav_dir, c, s);
          vel_v = clamp32(longint'(vel_v) + ((longint'(grav) * s + (longint'(1) << 29)) >>> 30));
          vel_h = clamp32(longint'(vel_h) + ((longint'(grav) * c + (longint'(1) << 29)) >>> 30));
        end
        if (drag != 0) begin
          h = vel_h;
          v = vel_v;
          mag = root64(longint'(h * h) + longint'(v * v));
          if (mag > drag) begin
            vel_h = drag_comp(vel_h, drag, mag);
            vel_v = drag_comp(vel_v, drag, mag);
          end else begin
            vel_h = 0;
            vel_v = 0;
          end
        end
        b = '{smas_pkg::EV_STEP, {2'b00, req.step_kind}, obj_x, obj_y, vel_h, vel_v, 1'b1};
        expected_beats.push_back(b);
      end
      default: ;
    endcase
  endtask

  initial misses = 0;

  always @(posedge clk) begin
    beat_t e;
    if (rst) begin
      obj_x = 0; obj_y = 0; vel_h = 0; vel_v = 0;
      foreach (alarm_cnt[i]) alarm_cnt[i] = -1;
      grav = 0;
      grav_dir = smas_pkg::ANGLE_RESET;
      drag = '0;
      expected_beats.delete();
    end else begin
      if (psel && penable && pwrite) begin
        case (paddr[3:2])
          smas_pkg::REG_GRAV_STRENGTH: grav = pwdata;
          smas_pkg::REG_GRAV_ANGLE:    grav_dir = pwdata[smas_pkg::ANGLE_W-1:0];
          smas_pkg::REG_FRICTION:      drag = pwdata[smas_pkg::FRIC_W-1:0];
          default: ;
        endcase
      end
      if (rsp.valid && rsp.ready) begin
        if (expected_beats.size() == 0) begin
          $error("unexpected rsp beat: kind %0d code %0d", rsp.event_kind, rsp.event_code);
          misses++;
        end else begin
          e = expected_beats.pop_front();
          check_field("event_kind", e.kind, rsp.event_kind);
          check_field("event_code", e.code, rsp.event_code);
          check_field("pos_x", e.px, rsp.pos_x);
          check_field("pos_y", e.py, rsp.pos_y);
          check_field("speed_h", e.sh, rsp.speed_h);
          check_field("speed_v", e.sv, rsp.speed_v);
          check_field("last", e.last, rsp.last);
        end
      end
      if (req.valid && req.ready) advance_object();
    end
    pending = expected_beats.size();
  end

endmodule

### test/sprite_motion_alarm_step_tb.sv
// Top of the sprite motion/alarm testbench: clock, reset, APB writes, req stimulus,
// rsp back-pressure and the verdict. Depends on smas_pkg, the interfaces, the block
// and smas_motion_checker.
module sprite_motion_alarm_step_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // drain wait covers the worst tick plus loads sitting in the 2-entry queue
  localparam int DRAIN_CYCLES = 250;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int HOLD_CYCLES  = 600;
  localparam int PHASE_ITEMS  = 60;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          misses, pending;
  int          cycles = 0;

  smas_in_if  req_ch();
  smas_out_if rsp_ch();

  sprite_motion_alarm_step DUT (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .req(req_ch), .rsp(rsp_ch)
  );

  smas_motion_checker scoreboard (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .req(req_ch), .rsp(rsp_ch),
    .misses(misses), .pending(pending)
  );

  always #2 clk = ~clk;

  initial begin
    req_ch.valid = 1'b0;
    req_ch.mode = smas_pkg::OP_NONE;
    req_ch.step_kind = '0;
    req_ch.alarm_slot = '0;
    req_ch.alarm_load = '0;
    req_ch.load_x = '0;
    req_ch.load_y = '0;
    req_ch.load_hspeed = '0;
    req_ch.load_vspeed = '0;
    rsp_ch.ready = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // rsp back-pressure: a random pattern, re-picked periodically; two long holds while the
  // sender keeps pushing, so the input queue fills and req.ready drops
  int hold_left = 0;
  int sink_style = 0;
  always @(posedge clk) begin
    if (cycles % 64 == 0) sink_style = $urandom_range(0, 3);
    if (cycles == 3000 || cycles == 20000) hold_left = HOLD_CYCLES;
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      rsp_ch.ready <= 1'b0;
    end else begin
      case (sink_style)
        0: rsp_ch.ready <= 1'b1;
        1: rsp_ch.ready <= ($urandom_range(0, 1) == 1);
        2: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
        default: rsp_ch.ready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  task automatic apb_write(input logic [1:0] idx, input logic [31:0] data);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic set_motion_cfg(input logic [31:0] g, input logic [31:0] ang,
                                input logic [31:0] fr);
    apb_write(smas_pkg::REG_GRAV_STRENGTH, g);
    apb_write(smas_pkg::REG_GRAV_ANGLE, ang);
    apb_write(smas_pkg::REG_FRICTION, fr);
    @(posedge clk);
  endtask

  // called right after a rising edge; returns at the edge that takes the beat
  task automatic offer_beat(input smas_pkg::item_t it);
    req_ch.valid <= 1'b1;
    req_ch.mode <= it.op;
    req_ch.step_kind <= it.step_kind;
    req_ch.alarm_slot <= it.alarm_slot;
    req_ch.alarm_load <= it.alarm_load;
    req_ch.load_x <= it.load_x;
    req_ch.load_y <= it.load_y;
    req_ch.load_hspeed <= it.load_hspeed;
    req_ch.load_vspeed <= it.load_vspeed;
    // ready only moves on rising edges, so sampling at the falling edge is race free
    do @(negedge clk); while (!req_ch.ready);
    @(posedge clk);
  endtask

  // first falling edge lets the scoreboard take in a beat accepted at this edge
  task automatic wait_drained();
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // park the sender and let the block go quiet before touching registers
  task automatic go_idle();
    req_ch.valid <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic smas_pkg::item_t make_item(input smas_pkg::op_e op);
    smas_pkg::item_t it;
    it = '0;
    it.op = op;
    return it;
  endfunction

  function automatic logic [31:0] rand_fix();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 7) return 32'($urandom_range(0, 2097151)) - 32'd1048576;
    if (pick < 9) return $urandom();
    return ($urandom_range(0, 1) == 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
  endfunction

  function automatic smas_pkg::item_t rand_item();
    smas_pkg::item_t it;
    int              pick;
    it = '0;
    pick = $urandom_range(0, 99);
    if (pick < 55)      it.op = smas_pkg::OP_TICK;
    else if (pick < 80) it.op = smas_pkg::OP_LOAD_ALARM;
    else if (pick < 95) it.op = smas_pkg::OP_LOAD_MOTION;
    else                it.op = smas_pkg::OP_NONE;
    it.step_kind = 2'($urandom_range(0, 3));
    it.alarm_slot = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(12, 15))
                                                : 4'($urandom_range(0, 11));
    pick = $urandom_range(0, 9);
    if (pick < 7)       it.alarm_load = 21'($urandom_range(0, 15));
    else if (pick == 7) it.alarm_load = -21'sd1;
    else                it.alarm_load = 21'($urandom());
    it.load_x = rand_fix();
    it.load_y = rand_fix();
    it.load_hspeed = rand_fix();
    it.load_vspeed = rand_fix();
    return it;
  endfunction

  // bursts of random length, often separated by random gaps
  task automatic random_phase(input int n_items, input bit pause_midway);
    int burst_left;
    burst_left = 0;
    for (int i = 0; i < n_items; i++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        if ($urandom_range(0, 2) != 0) begin
          req_ch.valid <= 1'b0;
          repeat ($urandom_range(1, 20)) @(posedge clk);
        end
      end
      if (pause_midway && i == n_items / 2) begin
        req_ch.valid <= 1'b0;
        wait_drained();
      end
      offer_beat(rand_item());
      burst_left--;
    end
  endtask

  initial begin
    smas_pkg::item_t it;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: every alarm set to fire on the same tick gives the longest beat train
    for (int i = 0; i < smas_pkg::NUM_ALARMS_DEF; i++) begin
      it = make_item(smas_pkg::OP_LOAD_ALARM);
      it.alarm_slot = 4'(i);
      it.alarm_load = '0;
      offer_beat(it);
    end
    it = make_item(smas_pkg::OP_LOAD_ALARM);    // out-of-range slot is ignored
    it.alarm_slot = 4'd15;
    it.alarm_load = '0;
    offer_beat(it);
    it = make_item(smas_pkg::OP_TICK);
    it.step_kind = 2'd3;
    offer_beat(it);
    it = make_item(smas_pkg::OP_LOAD_ALARM);    // largest count
    it.alarm_slot = 4'd0;
    it.alarm_load = 21'sh0F_FFFF;
    offer_beat(it);
    it = make_item(smas_pkg::OP_LOAD_ALARM);    // below -1 disables
    it.alarm_slot = 4'd11;
    it.alarm_load = 21'sh10_0000;
    offer_beat(it);
    it = make_item(smas_pkg::OP_LOAD_ALARM);    // -1 disables the big one again
    it.alarm_slot = 4'd0;
    it.alarm_load = -21'sd1;
    offer_beat(it);
    it = make_item(smas_pkg::OP_LOAD_MOTION);   // saturation at both rails
    it.load_x = 32'h7FFF_FFFF;
    it.load_y = 32'h8000_0000;
    it.load_hspeed = 32'h7FFF_FFFF;
    it.load_vspeed = 32'h8000_0000;
    offer_beat(it);
    offer_beat(make_item(smas_pkg::OP_NONE));
    it = make_item(smas_pkg::OP_TICK);
    it.step_kind = 2'd1;
    offer_beat(it);
    it.step_kind = 2'd2;
    offer_beat(it);
    it = make_item(smas_pkg::OP_LOAD_MOTION);   // x all ones, y all ones but the sign, speeds +1.0 and -1.0
    it.load_x = 32'hFFFF_FFFF;
    it.load_y = 32'h7FFF_FFFF;
    it.load_hspeed = 32'h0001_0000;
    it.load_vspeed = 32'hFFFF_0000;
    offer_beat(it);
    offer_beat(make_item(smas_pkg::OP_TICK));

    random_phase(PHASE_ITEMS / 2, 1'b0);
    go_idle();

    // friction larger than the loaded speed, but gravity is added first, so speed is not zeroed
    set_motion_cfg(32'h0001_0000, 32'($urandom_range(0, 92159)), 32'h0000_4000);
    it = make_item(smas_pkg::OP_LOAD_MOTION);
    it.load_hspeed = 32'h0000_1000;
    it.load_vspeed = 32'hFFFF_F000;
    offer_beat(it);
    it = make_item(smas_pkg::OP_TICK);
    offer_beat(it);
    random_phase(PHASE_ITEMS, 1'b1);
    go_idle();

    // extremes, angle past a full turn wraps
    set_motion_cfg(32'h8000_0000, 32'h0001_FFFF, 32'h7FFF_FFFF);
    random_phase(PHASE_ITEMS / 2, 1'b0);
    go_idle();

    set_motion_cfg(32'h7FFF_FFFF, 32'd0, 32'd1);
    random_phase(PHASE_ITEMS / 2, 1'b0);
    go_idle();

    set_motion_cfg($urandom(), 32'($urandom_range(0, 131071)), $urandom() & 32'h7FFF_FFFF);
    random_phase(PHASE_ITEMS, 1'b0);
    go_idle();

    // friction off, half gravity at a 90 degree quadrant edge
    set_motion_cfg(32'h0000_8000, 32'd23040, 32'd0);
    random_phase(PHASE_ITEMS / 2, 1'b0);
    req_ch.valid <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (misses == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### sim.f
rtl/smas_pkg.sv
rtl/smas_if.sv
rtl/smas_front.sv
rtl/smas_back.sv
rtl/sprite_motion_alarm_step.sv
test/smas_motion_checker.sv
test/sprite_motion_alarm_step_tb.sv
